### hdl/slot_allocator_with_ring_list_unit_assert.svh
// ----------------------------------------------------------------------------
// slot allocator assertion macros
// shared assertion helpers, empty bodies when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_WITH_RING_LIST_UNIT_ASSERT_SVH
`define SLOT_ALLOCATOR_WITH_RING_LIST_UNIT_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define SAL_AST_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define SAL_AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAL_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SAL_AST_ALWAYS(lbl, expr, msg)
`define SAL_AST_IMPLY(lbl, ante, cons, msg)
`define SAL_AST_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// constants, codes and shared types of the slot allocator
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // port payload widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int FIELD_SLOT_W  = 10;
  localparam int FIELD_COUNT_W = 11;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_EXEC,
    S_LINK
  } sal_state_t;

  // requests to the free-slot stack
  typedef struct packed {
    logic              rd;
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
  } stk_cmd_t;

  // stack status back to the control
  typedef struct packed {
    logic              empty;
    logic [SLOT_W-1:0] top_slot;
  } stk_stat_t;

endpackage

### hdl/sal_free_stack.sv
// ----------------------------------------------------------------------------
// sal_free_stack
// stack of free slot numbers in a synchronous memory; a low-water mark
// stands in for the reset contents of entries never written
// ----------------------------------------------------------------------------
`include "slot_allocator_with_ring_list_unit_assert.svh"

module sal_free_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  sal_pkg::stk_cmd_t   cmd,
  output sal_pkg::stk_stat_t  stat
);
  import sal_pkg::*;

  logic [SLOT_W-1:0] mem [SLOTS];

  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [CNT_W-1:0]  lw_r, lw_nxt;
  logic [SLOT_W-1:0] rd_data_r;
  logic [SLOT_W-1:0] idx_r;
  logic              fresh_r;

  logic [CNT_W-1:0]  top_full;
  logic [SLOT_W-1:0] top_idx;
  logic              push_ok;

  assign top_full = depth_r - CNT_W'(1);
  assign top_idx  = top_full[SLOT_W-1:0];
  assign push_ok  = cmd.push && (depth_r != CNT_W'(SLOTS));

  always_comb begin
    depth_nxt = depth_r;
    lw_nxt    = lw_r;
    if (cmd.pop) begin
      depth_nxt = top_full;
      if (top_full < lw_r) begin
        lw_nxt = top_full;
      end
    end else if (push_ok) begin
      depth_nxt = depth_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= CNT_W'(SLOTS);
      lw_r    <= CNT_W'(SLOTS);
    end else begin
      depth_r <= depth_nxt;
      lw_r    <= lw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[depth_r[SLOT_W-1:0]] <= cmd.push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[top_idx];
      idx_r     <= top_idx;
      // below the low-water mark the entry still holds its reset value
      fresh_r   <= (top_full < lw_r);
    end
  end

  assign stat.empty    = (depth_r == '0);
  assign stat.top_slot = fresh_r ? (SLOT_W'(SLOTS - 1) - idx_r) : rd_data_r;

  `SAL_AST_ALWAYS(a_depth_range, depth_r <= CNT_W'(SLOTS), "stack depth above pool size")
  `SAL_AST_ALWAYS(a_lw_below_depth, lw_r <= depth_r, "low-water mark above depth")
  `SAL_AST_ALWAYS(a_pop_push_excl, !(cmd.pop && cmd.push), "pop and push together")
  `SAL_AST_IMPLY(a_pop_nonempty, cmd.pop, depth_r != '0, "pop from empty stack")

endmodule

### hdl/slot_allocator_with_ring_list_unit.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_ring_list_unit
// slot pool with a free stack and a circular doubly linked ring of live slots
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_       in   in_tvalid/in_tready  tuser: action; tdata: slot
//  out_      out  out_tvalid/out_tready tdata: status, slot, count, tail, flag
//
//  an item passes S_IDLE and S_EXEC, and an allocate into a non-empty ring
//  also S_LINK: the single write port of each link memory splits the splice
//  after reset the live-flag memory is swept, one entry a cycle, over all
//  SLOTS (1024) entries while in_tready stays low
//  a finished result waits in the output register; the next item is taken
//  while it waits, and only the final step of an item stalls on a full output
// ----------------------------------------------------------------------------
`include "slot_allocator_with_ring_list_unit_assert.svh"

module slot_allocator_with_ring_list_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [9:0] slot
  input  logic [sal_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] action
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] status, [11:2] granted_slot, [22:12] live_count,
  // [32:23] tail_slot, [33] tail_valid
  output logic [sal_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import sal_pkg::*;

  logic [SLOT_W-1:0] next_mem [SLOTS];
  logic [SLOT_W-1:0] prev_mem [SLOTS];
  logic              live_mem [SLOTS];

  sal_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic              nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              act_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] next_rd_r, prev_rd_r;
  logic              live_rd_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [SLOT_W-1:0] out_tail_r;
  logic              out_tvld_r;

  logic              accept, go, fin;
  logic [SLOT_W-1:0] in_slot;
  logic [SLOT_W-1:0] nrd_addr;
  logic [1:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] s_slot;

  logic              nw_en, pw_en, lw_en;
  logic [SLOT_W-1:0] nw_addr, nw_data, pw_addr, pw_data, lw_addr;
  logic              lw_data;

  stk_cmd_t          stk_cmd;
  stk_stat_t         stk_stat;

  sal_free_stack u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (stk_cmd),
    .stat (stk_stat)
  );

  assign in_slot  = in_tdata[SLOT_W-1:0];
  assign accept   = in_tvalid && in_tready;
  assign go       = !out_valid_r || out_tready;
  assign s_slot   = stk_stat.top_slot;
  assign nrd_addr = (in_tuser[0] == ACT_ALLOC) ? tail_r : in_slot;

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    count_nxt    = count_r;
    fin          = 1'b0;
    in_tready    = 1'b0;
    res_status   = ST_OK;
    res_slot     = '0;
    nw_en = 1'b0; nw_addr = '0; nw_data = '0;
    pw_en = 1'b0; pw_addr = '0; pw_data = '0;
    lw_en = 1'b0; lw_addr = '0; lw_data = 1'b0;
    stk_cmd = '0;
    case (state_r)
      S_CLR: begin
        lw_en       = 1'b1;
        lw_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready  = 1'b1;
        stk_cmd.rd = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (act_r == ACT_ALLOC) begin
          if (stk_stat.empty) begin
            res_status = ST_EMPTY;
            fin        = go;
          end else if (nonempty_r) begin
            // first half of the splice: links of the new slot
            nw_en = 1'b1; nw_addr = s_slot; nw_data = next_rd_r;
            pw_en = 1'b1; pw_addr = s_slot; pw_data = tail_r;
            lw_en = 1'b1; lw_addr = s_slot; lw_data = 1'b1;
            state_nxt = S_LINK;
          end else begin
            res_slot = s_slot;
            nw_en = go; nw_addr = s_slot; nw_data = s_slot;
            pw_en = go; pw_addr = s_slot; pw_data = s_slot;
            lw_en = go; lw_addr = s_slot; lw_data = 1'b1;
            stk_cmd.pop  = go;
            tail_nxt     = s_slot;
            nonempty_nxt = 1'b1;
            count_nxt    = count_r + CNT_W'(1);
            fin          = go;
          end
        end else begin
          res_slot = slot_r;
          if (!live_rd_r) begin
            res_status = ST_NOT_LIVE;
            fin        = go;
          end else begin
            nw_en = go; nw_addr = prev_rd_r; nw_data = next_rd_r;
            pw_en = go; pw_addr = next_rd_r; pw_data = prev_rd_r;
            lw_en = go; lw_addr = slot_r;    lw_data = 1'b0;
            stk_cmd.push      = go;
            stk_cmd.push_slot = slot_r;
            count_nxt         = count_r - CNT_W'(1);
            if (nonempty_r && (slot_r == tail_r)) begin
              if (prev_rd_r == slot_r) begin
                tail_nxt     = '0;
                nonempty_nxt = 1'b0;
              end else begin
                tail_nxt = prev_rd_r;
              end
            end
            fin = go;
          end
        end
        if (fin) begin
          state_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        // second half: neighbors point at the new slot
        res_slot = s_slot;
        nw_en = go; nw_addr = tail_r;    nw_data = s_slot;
        pw_en = go; pw_addr = next_rd_r; pw_data = s_slot;
        stk_cmd.pop = go;
        tail_nxt    = s_slot;
        count_nxt   = count_r + CNT_W'(1);
        fin         = go;
        if (go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      if (fin) begin
        tail_r     <= tail_nxt;
        nonempty_r <= nonempty_nxt;
        count_r    <= count_nxt;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= in_tuser[0];
      slot_r <= in_slot;
    end
    if (fin) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_count_r  <= count_nxt;
      out_tail_r   <= tail_nxt;
      out_tvld_r   <= nonempty_nxt;
    end
  end

  // link and flag memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (accept) begin
      next_rd_r <= next_mem[nrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (accept) begin
      prev_rd_r <= prev_mem[in_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      live_mem[lw_addr] <= lw_data;
    end
    if (accept) begin
      live_rd_r <= live_mem[in_slot];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 - 2*FIELD_SLOT_W - FIELD_COUNT_W - 1){1'b0}},
                       out_tvld_r, out_tail_r, out_count_r, out_slot_r, out_status_r};

  `SAL_AST_ALWAYS(a_ring_flag, nonempty_r == (count_r != '0), "ring flag and count disagree")
  `SAL_AST_IMPLY(a_empty_tail, !nonempty_r, tail_r == '0, "empty ring with nonzero tail")
  `SAL_AST_NEXT(a_link_result, (state_r == S_LINK) && go, out_tvalid, "splice gave no result")
  `SAL_AST_IMPLY(a_no_accept_in_clear, state_r == S_CLR, !in_tready, "ready during sweep")

endmodule
